// ----- src/ata_tf_pkg.sv -----
// Shared types and constants for the ATA task-file address setup block.
// Holds the request and result structs, addressing-mode codes and command bytes.
// No dependencies.
package ata_tf_pkg;

    // Addressing mode reported with each result.
    typedef enum logic [1:0] {
        ADDR_CHS   = 2'd0,
        ADDR_LBA28 = 2'd1,
        ADDR_LBA48 = 2'd2
    } t_addr_mode;

    // Transfer direction of a request.
    localparam logic DIR_READ  = 1'b0;
    localparam logic DIR_WRITE = 1'b1;

    // Device/head register bases.
    localparam logic [7:0] DEVHEAD_CHS = 8'hA0;
    localparam logic [7:0] DEVHEAD_LBA = 8'hE0;

    // PIO and cache-flush command bytes.
    localparam logic [7:0] CMD_READ        = 8'h20;
    localparam logic [7:0] CMD_READ_EXT    = 8'h24;
    localparam logic [7:0] CMD_WRITE       = 8'h30;
    localparam logic [7:0] CMD_WRITE_EXT   = 8'h34;
    localparam logic [7:0] CMD_FLUSH       = 8'hE7;
    localparam logic [7:0] CMD_FLUSH_EXT   = 8'hEA;
    localparam logic [7:0] CMD_NONE        = 8'h00;

    // CHS geometry: 16 heads, 63 sectors per track.
    localparam int unsigned SECTORS_PER_TRACK = 63;
    localparam int unsigned LBA28_BITS        = 28;
    // Reciprocal of 63 scaled by 2^34, rounded up; exact for all 28-bit addresses.
    localparam int unsigned RECIP_SHIFT       = 34;
    localparam logic [28:0] RECIP_63          = 29'd272696337;

    // One sector access request.
    typedef struct packed {
        logic        mode;
        logic [31:0] sector_address;
        logic [7:0]  sector_total;
        logic        device_select;
        logic        lba_capable;
    } t_request;

    // One set of task-file values.
    typedef struct packed {
        t_addr_mode  addr_mode;
        logic [7:0]  device_head;
        logic [7:0]  count_low;
        logic [7:0]  count_high;
        logic [7:0]  addr_byte0;
        logic [7:0]  addr_byte1;
        logic [7:0]  addr_byte2;
        logic [7:0]  addr_byte3;
        logic [7:0]  command_byte;
        logic [7:0]  flush_byte;
    } t_result;

endpackage

// ----- src/ata_tf_chs.sv -----
// CHS geometry conversion of a 28-bit block address (16 heads, 63 sectors).
// Uses constants from ata_tf_pkg.
module ata_tf_chs (
    input  logic [27:0] i_lba,
    output logic [5:0]  o_sector,
    output logic [3:0]  o_head,
    output logic [15:0] o_cylinder
);

    logic [56:0] w_product;
    logic [22:0] w_track;
    logic [27:0] w_track_start;
    logic [27:0] w_remainder;

    // Track index as address / 63, by multiplying with the scaled reciprocal.
    assign w_product = 57'(i_lba) * 57'(ata_tf_pkg::RECIP_63);
    assign w_track   = w_product[ata_tf_pkg::RECIP_SHIFT +: 23];

    // Sector within the track is the remainder; 63 * track is a shift and subtract.
    assign w_track_start = 28'({w_track, 6'b0} - {6'b0, w_track});
    assign w_remainder   = i_lba - w_track_start;
    assign o_sector      = w_remainder[5:0] + 6'd1;

    // Sixteen tracks make a cylinder; the cylinder keeps only its low 16 bits.
    assign o_head     = w_track[3:0];
    assign o_cylinder = w_track[19:4];

endmodule

// ----- src/ata_tf_encode.sv -----
// Chooses the addressing mode and builds the task-file values for one request.
// Depends on ata_tf_pkg and ata_tf_chs.
module ata_tf_encode (
    input  ata_tf_pkg::t_request i_request,
    output ata_tf_pkg::t_result  o_result
);

    logic [5:0]             w_sector;
    logic [3:0]             w_head_chs;
    logic [15:0]            w_cylinder;
    ata_tf_pkg::t_addr_mode w_mode;
    logic [3:0]             w_head;
    logic                   w_ext;

    ata_tf_chs u_chs (
        .i_lba      (i_request.sector_address[27:0]),
        .o_sector   (w_sector),
        .o_head     (w_head_chs),
        .o_cylinder (w_cylinder)
    );

    // Addresses at or above 2^28 need LBA48; otherwise LBA28 when the drive allows it.
    always_comb begin
        if (i_request.sector_address[31:ata_tf_pkg::LBA28_BITS] != '0) begin
            w_mode = ata_tf_pkg::ADDR_LBA48;
        end else if (i_request.lba_capable) begin
            w_mode = ata_tf_pkg::ADDR_LBA28;
        end else begin
            w_mode = ata_tf_pkg::ADDR_CHS;
        end
    end

    assign w_ext = (w_mode == ata_tf_pkg::ADDR_LBA48);

    // Address bytes and head nibble for each mode.
    always_comb begin
        o_result            = '0;
        o_result.addr_mode  = w_mode;
        o_result.count_low  = i_request.sector_total;
        o_result.count_high = 8'h00;
        unique case (w_mode)
            ata_tf_pkg::ADDR_LBA48: begin
                o_result.addr_byte0 = i_request.sector_address[7:0];
                o_result.addr_byte1 = i_request.sector_address[15:8];
                o_result.addr_byte2 = i_request.sector_address[23:16];
                o_result.addr_byte3 = i_request.sector_address[31:24];
                w_head              = 4'h0;
            end
            ata_tf_pkg::ADDR_LBA28: begin
                o_result.addr_byte0 = i_request.sector_address[7:0];
                o_result.addr_byte1 = i_request.sector_address[15:8];
                o_result.addr_byte2 = i_request.sector_address[23:16];
                o_result.addr_byte3 = 8'h00;
                w_head              = i_request.sector_address[27:24];
            end
            default: begin
                o_result.addr_byte0 = {2'b00, w_sector};
                o_result.addr_byte1 = w_cylinder[7:0];
                o_result.addr_byte2 = w_cylinder[15:8];
                o_result.addr_byte3 = 8'h00;
                w_head              = w_head_chs;
            end
        endcase

        // Device/head byte: mode base, slave select in bit 4, head nibble.
        o_result.device_head = ((w_mode == ata_tf_pkg::ADDR_CHS) ? ata_tf_pkg::DEVHEAD_CHS
                                                                  : ata_tf_pkg::DEVHEAD_LBA)
                             | {3'b000, i_request.device_select, w_head};

        // Command bytes; a read carries no flush command.
        if (i_request.mode == ata_tf_pkg::DIR_WRITE) begin
            o_result.command_byte = w_ext ? ata_tf_pkg::CMD_WRITE_EXT : ata_tf_pkg::CMD_WRITE;
            o_result.flush_byte   = w_ext ? ata_tf_pkg::CMD_FLUSH_EXT : ata_tf_pkg::CMD_FLUSH;
        end else begin
            o_result.command_byte = w_ext ? ata_tf_pkg::CMD_READ_EXT : ata_tf_pkg::CMD_READ;
            o_result.flush_byte   = ata_tf_pkg::CMD_NONE;
        end
    end

endmodule

// ----- src/ata_taskfile_address_setup.sv -----
// Top level of the ATA task-file address setup block: request and result registers.
// Depends on ata_tf_pkg and ata_tf_encode.
//
//  Channel   Signals                      Handshake
//  --------  ---------------------------  ---------------------------------------
//  request   start, busy, i_request       taken at an edge with start high, busy low
//  result    o_result_valid, o_result     shown for one cycle, cannot be held off
//
// A request is registered at the edge that takes it; its result is registered at
// the next edge and shown for one cycle. busy never rises,
// so a request may be taken every cycle and results follow at the same rate.
// The single path of work is the reciprocal multiply of the CHS conversion.
// Reset (synchronous, active low) drops any request in flight and any result.
module ata_taskfile_address_setup (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ata_tf_pkg::t_request i_request,
    output logic                 o_result_valid,
    output ata_tf_pkg::t_result  o_result
);

    ata_tf_pkg::t_request r_request;
    logic                 r_request_valid;
    ata_tf_pkg::t_result  r_result;
    logic                 r_result_valid;
    ata_tf_pkg::t_result  n_result;

    assign busy = 1'b0;

    // Request register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_request_valid <= 1'b0;
        end else begin
            r_request_valid <= start && !busy;
        end
        if (start && !busy) begin
            r_request <= i_request;
        end
    end

    ata_tf_encode u_encode (
        .i_request (r_request),
        .o_result  (n_result)
    );

    // Result register; each result stays for exactly one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= r_request_valid;
        end
        if (r_request_valid) begin
            r_result <= n_result;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the ATA task-file address setup block.
// Drives directed and random sector access requests and compares every result with its
// own prediction of the task-file values. Depends on ata_tf_pkg and the block itself.

// Holds the predicted task-file values for requests taken and checks results against them.
class taskfile_scoreboard;
    ata_tf_pkg::t_result pending_taskfiles[$];
    int                  errors = 0;

    // Prints one line for a mismatch and counts it.
    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
        errors++;
    endtask

    task compare(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report(what, got, want);
        end
    endtask

    // Works out the task-file values that one request should give.
    function ata_tf_pkg::t_result taskfile_for(ata_tf_pkg::t_request rq);
        ata_tf_pkg::t_result tf;
        logic [31:0]         lba;
        logic [31:0]         sect;
        logic [31:0]         track;
        logic [31:0]         cyl;
        logic [31:0]         head;
        logic [7:0]          base;
        tf = '0;
        lba = rq.sector_address;
        if (lba >= (32'd1 << ata_tf_pkg::LBA28_BITS)) begin
            // Addresses beyond 28 bits need the extended commands.
            tf.addr_mode  = ata_tf_pkg::ADDR_LBA48;
            tf.addr_byte0 = lba[7:0];
            tf.addr_byte1 = lba[15:8];
            tf.addr_byte2 = lba[23:16];
            tf.addr_byte3 = lba[31:24];
            head = 0;
        end else if (rq.lba_capable) begin
            // LBA28 puts address bits 27:24 in the head nibble.
            tf.addr_mode  = ata_tf_pkg::ADDR_LBA28;
            tf.addr_byte0 = lba[7:0];
            tf.addr_byte1 = lba[15:8];
            tf.addr_byte2 = lba[23:16];
            head = {28'd0, lba[27:24]};
        end else begin
            // CHS with 16 heads and 63 sectors per track; the cylinder keeps 16 bits.
            tf.addr_mode  = ata_tf_pkg::ADDR_CHS;
            sect  = (lba % ata_tf_pkg::SECTORS_PER_TRACK) + 1;
            track = lba + 1 - sect;
            cyl   = track / (16 * ata_tf_pkg::SECTORS_PER_TRACK);
            head  = (track % (16 * ata_tf_pkg::SECTORS_PER_TRACK))
                    / ata_tf_pkg::SECTORS_PER_TRACK;
            tf.addr_byte0 = sect[7:0];
            tf.addr_byte1 = cyl[7:0];
            tf.addr_byte2 = cyl[15:8];
        end
        base = (tf.addr_mode == ata_tf_pkg::ADDR_CHS) ? ata_tf_pkg::DEVHEAD_CHS
                                                      : ata_tf_pkg::DEVHEAD_LBA;
        tf.device_head = base | {3'd0, rq.device_select, 4'd0} | {4'd0, head[3:0]};
        tf.count_low   = rq.sector_total;
        tf.count_high  = 8'd0;
        if (rq.mode == ata_tf_pkg::DIR_WRITE) begin
            tf.command_byte = (tf.addr_mode == ata_tf_pkg::ADDR_LBA48)
                              ? ata_tf_pkg::CMD_WRITE_EXT : ata_tf_pkg::CMD_WRITE;
            tf.flush_byte   = (tf.addr_mode == ata_tf_pkg::ADDR_LBA48)
                              ? ata_tf_pkg::CMD_FLUSH_EXT : ata_tf_pkg::CMD_FLUSH;
        end else begin
            tf.command_byte = (tf.addr_mode == ata_tf_pkg::ADDR_LBA48)
                              ? ata_tf_pkg::CMD_READ_EXT : ata_tf_pkg::CMD_READ;
            tf.flush_byte   = ata_tf_pkg::CMD_NONE;
        end
        return tf;
    endfunction

    // Notes a request taken by the block.
    function void note(ata_tf_pkg::t_request rq);
        pending_taskfiles.push_back(taskfile_for(rq));
    endfunction

    // Checks one result against the oldest prediction.
    task check(ata_tf_pkg::t_result got);
        ata_tf_pkg::t_result want;
        if (pending_taskfiles.size() == 0) begin
            report("unexpected result", got[31:0], 32'd0);
        end else begin
            want = pending_taskfiles.pop_front();
            compare("addr_mode", 32'(got.addr_mode), 32'(want.addr_mode));
            compare("device_head", 32'(got.device_head), 32'(want.device_head));
            compare("count_low", 32'(got.count_low), 32'(want.count_low));
            compare("count_high", 32'(got.count_high), 32'(want.count_high));
            compare("addr_byte0", 32'(got.addr_byte0), 32'(want.addr_byte0));
            compare("addr_byte1", 32'(got.addr_byte1), 32'(want.addr_byte1));
            compare("addr_byte2", 32'(got.addr_byte2), 32'(want.addr_byte2));
            compare("addr_byte3", 32'(got.addr_byte3), 32'(want.addr_byte3));
            compare("command_byte", 32'(got.command_byte), 32'(want.command_byte));
            compare("flush_byte", 32'(got.flush_byte), 32'(want.flush_byte));
        end
    endtask

    function int pending();
        return pending_taskfiles.size();
    endfunction
endclass

module tb_top;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1550;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    ata_tf_pkg::t_request i_request;
    logic                 o_result_valid;
    ata_tf_pkg::t_result  o_result;

    taskfile_scoreboard sb;
    int unsigned        cycles = 0;

    ata_taskfile_address_setup uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_request      (i_request),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // Clock with a period of 12.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watch both channels at each edge; results are checked before the new request
    // is noted, since a result never belongs to the request taken at the same edge.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
        if (i_rst_n) begin
            if (o_result_valid) begin
                sb.check(o_result);
            end
            if (start && !busy) begin
                sb.note(i_request);
            end
        end
    end

    // Presents one request and holds it until the block takes it.
    task send_request(ata_tf_pkg::t_request rq);
        start     <= 1'b1;
        i_request <= rq;
        do @(posedge i_clk); while (busy);
    endtask

    // Leaves the request channel idle for a number of cycles.
    task idle_for(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Stops sending until every predicted result has arrived.
    task drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic ata_tf_pkg::t_request make_request(logic wr, logic [31:0] lba,
                                                          logic [7:0] cnt, logic slave,
                                                          logic lba_ok);
        ata_tf_pkg::t_request rq;
        rq.mode           = wr;
        rq.sector_address = lba;
        rq.sector_total   = cnt;
        rq.device_select  = slave;
        rq.lba_capable    = lba_ok;
        return rq;
    endfunction

    // Random request; addresses are weighted towards the mode and geometry boundaries.
    function automatic ata_tf_pkg::t_request random_request();
        logic [31:0] lba;
        logic [7:0]  cnt;
        int unsigned kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: lba = $urandom;
            3, 4, 5: lba = $urandom & 32'h0FFF_FFFF;
            6:       lba = $urandom_range(0, 4095);
            7:       lba = 32'h1000_0000 + $urandom_range(0, 127) - 64;
            8: begin
                lba = 1008 * $urandom_range(0, 5000);
                case ($urandom_range(0, 3))
                    0: lba = lba;
                    1: lba = lba + 62;
                    2: lba = lba + 63;
                    default: lba = lba + 1007;
                endcase
            end
            default: lba = 32'd66060288 + $urandom_range(0, 4095) - 2048;
        endcase
        case ($urandom_range(0, 7))
            0:       cnt = 8'd0;
            1:       cnt = 8'hFF;
            default: cnt = 8'($urandom);
        endcase
        return make_request(1'($urandom_range(0, 1)), lba, cnt, 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
    endfunction

    // Main sequence: reset, directed requests, random bursts, then the final check.
    initial begin
        ata_tf_pkg::t_request directed[$];
        int                   sent;
        int                   burst;
        bit                   drained_once;
        sb = new;
        start     <= 1'b0;
        i_request <= '0;
        i_rst_n   <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Address extremes, mode thresholds, geometry edges and cylinder wrap.
        directed.push_back(make_request(ata_tf_pkg::DIR_READ, 32'h0000_0000, 8'd0,
                                        1'b0, 1'b0));
        directed.push_back(make_request(ata_tf_pkg::DIR_WRITE, 32'h0000_0000, 8'hFF,
                                        1'b1, 1'b1));
        directed.push_back(make_request(ata_tf_pkg::DIR_READ, 32'd62, 8'd1, 1'b0, 1'b0));
        directed.push_back(make_request(ata_tf_pkg::DIR_WRITE, 32'd63, 8'd2, 1'b1, 1'b0));
        directed.push_back(make_request(ata_tf_pkg::DIR_READ, 32'd1007, 8'd3, 1'b1, 1'b0));
        directed.push_back(make_request(ata_tf_pkg::DIR_WRITE, 32'd1008, 8'd4,
                                        1'b0, 1'b0));
        directed.push_back(make_request(ata_tf_pkg::DIR_READ, 32'd66060287, 8'd5,
                                        1'b0, 1'b0));
        directed.push_back(make_request(ata_tf_pkg::DIR_WRITE, 32'd66060288, 8'd6,
                                        1'b1, 1'b0));
        directed.push_back(make_request(ata_tf_pkg::DIR_READ, 32'h0FFF_FFFF, 8'hFF,
                                        1'b1, 1'b0));
        directed.push_back(make_request(ata_tf_pkg::DIR_WRITE, 32'h0FFF_FFFF, 8'd0,
                                        1'b0, 1'b1));
        directed.push_back(make_request(ata_tf_pkg::DIR_READ, 32'h0F00_0000, 8'd7,
                                        1'b1, 1'b1));
        directed.push_back(make_request(ata_tf_pkg::DIR_WRITE, 32'h0ABC_DEF1, 8'd8,
                                        1'b0, 1'b1));
        directed.push_back(make_request(ata_tf_pkg::DIR_READ, 32'h1000_0000, 8'd0,
                                        1'b0, 1'b0));
        directed.push_back(make_request(ata_tf_pkg::DIR_WRITE, 32'h1000_0000, 8'hFF,
                                        1'b1, 1'b1));
        directed.push_back(make_request(ata_tf_pkg::DIR_READ, 32'hFFFF_FFFF, 8'd9,
                                        1'b1, 1'b1));
        directed.push_back(make_request(ata_tf_pkg::DIR_WRITE, 32'hFFFF_FFFF, 8'd10,
                                        1'b0, 1'b0));
        directed.push_back(make_request(ata_tf_pkg::DIR_READ, 32'h8765_4321, 8'h80,
                                        1'b0, 1'b1));
        directed.push_back(make_request(ata_tf_pkg::DIR_WRITE, 32'h5555_5555, 8'h55,
                                        1'b1, 1'b0));
        directed.push_back(make_request(ata_tf_pkg::DIR_READ, 32'hAAAA_AAAA, 8'hAA,
                                        1'b0, 1'b1));
        foreach (directed[i]) begin
            send_request(directed[i]);
        end
        drain_results();

        // Random bursts with random gaps, draining fully once midway.
        sent = 0;
        drained_once = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                send_request(random_request());
                sent++;
            end
            if (!drained_once && sent >= RANDOM_ITEMS / 2) begin
                drain_results();
                drained_once = 1'b1;
            end else if ($urandom_range(0, 3) != 0) begin
                idle_for($urandom_range(1, 6));
            end
        end

        // Wait for the last results, then allow for the pipeline depth.
        drain_results();
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.report("results missing", sb.pending(), 32'd0);
        end
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/ata_tf_pkg.sv
src/ata_tf_chs.sv
src/ata_tf_encode.sv
src/ata_taskfile_address_setup.sv
tb/tb_top.sv
